// ===== sv/snep_ft_pkg.sv =====
// ============================================================================
// snep_ft_pkg
// Shared types, codes and sizes for the SNEP PDU fragment tracker.
// ============================================================================
`default_nettype none

package snep_ft_pkg;

    localparam int OPEN_MESSAGES = 8;
    localparam int HEADER_BYTES  = 6;
    localparam int IDX_W         = (OPEN_MESSAGES > 1) ? $clog2(OPEN_MESSAGES) : 1;
    localparam int KEY_W         = 21;
    localparam int DIR_BIT       = 12;

    // result status codes
    localparam logic [3:0] ST_SHORT    = 4'd0;
    localparam logic [3:0] ST_FRAG     = 4'd1;
    localparam logic [3:0] ST_DONE     = 4'd2;
    localparam logic [3:0] ST_OVER     = 4'd3;
    localparam logic [3:0] ST_WHOLE    = 4'd4;
    localparam logic [3:0] ST_START    = 4'd5;
    localparam logic [3:0] ST_NODATA   = 4'd6;
    localparam logic [3:0] ST_REJECT   = 4'd7;
    localparam logic [3:0] ST_BADCODE  = 4'd8;
    localparam logic [3:0] ST_GETSHORT = 4'd9;
    localparam logic [3:0] ST_FULL     = 4'd10;
    localparam logic [3:0] ST_STATUS   = 4'd11;

    // SNEP request and response codes
    localparam logic [7:0] CODE_CONT_REQ   = 8'h00;
    localparam logic [7:0] CODE_GET        = 8'h01;
    localparam logic [7:0] CODE_PUT        = 8'h02;
    localparam logic [7:0] CODE_REJECT_REQ = 8'h7f;
    localparam logic [7:0] CODE_CONT_RSP   = 8'h80;
    localparam logic [7:0] CODE_SUCCESS    = 8'h81;
    localparam logic [7:0] CODE_NOT_FOUND  = 8'hc0;
    localparam logic [7:0] CODE_EXCESS     = 8'hc1;
    localparam logic [7:0] CODE_BAD_REQ    = 8'hc2;
    localparam logic [7:0] CODE_NOT_IMPL   = 8'he0;
    localparam logic [7:0] CODE_UNSUPP     = 8'he1;
    localparam logic [7:0] CODE_REJECT_RSP = 8'hff;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;

    // per-entry payload held in the table memory
    typedef struct packed {
        logic [15:0] count;
        logic [31:0] received;
        logic [31:0] expected;
    } entry_t;

    // key lookup answers
    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic rev_hit;
        idx_t rev_idx;
        logic free_avail;
        idx_t free_idx;
    } lookup_t;

    // key table update request
    typedef struct packed {
        logic set_en;
        idx_t set_idx;
        key_t set_key;
        logic clr_en;
        idx_t clr_idx;
    } cam_upd_t;

    // one result word
    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  version_major;
        logic [3:0]  version_minor;
        logic [31:0] get_max_len;
        logic [15:0] fragment_number;
        logic [31:0] bytes_received;
        logic [31:0] bytes_expected;
    } res_t;

    // header decode outcome on a key miss
    typedef struct packed {
        res_t res;
        logic alloc;
        logic reject;
    } hdr_t;

endpackage

`default_nettype wire

// ===== sv/snep_ft_cam.sv =====
// ============================================================================
// snep_ft_cam
// Valid bits and keys of the open-message table, with parallel key match.
// ============================================================================
`default_nettype none

module snep_ft_cam (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire snep_ft_pkg::key_t    key,
    input  wire snep_ft_pkg::cam_upd_t upd,
    output snep_ft_pkg::lookup_t      lookup
);
    import snep_ft_pkg::*;

    logic [OPEN_MESSAGES-1:0] valid_reg;
    logic [OPEN_MESSAGES-1:0] valid_next;
    key_t                     key_reg [OPEN_MESSAGES];

    key_t rev_key;
    assign rev_key = key ^ (key_t'(1) << DIR_BIT);

    // lowest index wins: scan downward so the last assignment is the lowest
    always_comb
    begin
        lookup = '0;
        for (int i = OPEN_MESSAGES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == key))
            begin
                lookup.hit     = 1'b1;
                lookup.hit_idx = idx_t'(i);
            end
            if (valid_reg[i] && (key_reg[i] == rev_key))
            begin
                lookup.rev_hit = 1'b1;
                lookup.rev_idx = idx_t'(i);
            end
            if (!valid_reg[i])
            begin
                lookup.free_avail = 1'b1;
                lookup.free_idx   = idx_t'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (upd.clr_en)
        begin
            valid_next[upd.clr_idx] = 1'b0;
        end
        if (upd.set_en)
        begin
            valid_next[upd.set_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.set_en)
        begin
            key_reg[upd.set_idx] <= upd.set_key;
        end
    end

endmodule

`default_nettype wire

// ===== sv/snep_ft_ram.sv =====
// ============================================================================
// snep_ft_ram
// Table memory for count, received and expected bytes; registered read.
// ============================================================================
`default_nettype none

module snep_ft_ram (
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire snep_ft_pkg::idx_t   rd_addr,
    output snep_ft_pkg::entry_t      rd_data,
    input  wire logic                wr_en,
    input  wire snep_ft_pkg::idx_t   wr_addr,
    input  wire snep_ft_pkg::entry_t wr_data
);
    import snep_ft_pkg::*;

    entry_t mem [OPEN_MESSAGES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/snep_ft_hdr.sv =====
// ============================================================================
// snep_ft_hdr
// Header decode for a PDU that opens no known fragment: code, lengths, alloc.
// ============================================================================
`default_nettype none

module snep_ft_hdr (
    input  wire logic [15:0] payload_len,
    input  wire logic [7:0]  version_byte,
    input  wire logic [7:0]  code_byte,
    input  wire logic [31:0] declared_len,
    input  wire logic [31:0] first_word,
    input  wire logic        free_avail,
    output snep_ft_pkg::hdr_t hdr
);
    import snep_ft_pkg::*;

    always_comb
    begin
        logic [31:0] info_len;
        logic [31:0] decl;
        logic        info;

        hdr      = '0;
        info_len = {16'd0, payload_len} - 32'(HEADER_BYTES);
        decl     = declared_len;
        info     = 1'b0;

        if (payload_len < 16'(HEADER_BYTES))
        begin
            hdr.res.status = ST_SHORT;
        end
        else
        begin
            hdr.res.version_major = version_byte[7:4];
            hdr.res.version_minor = version_byte[3:0];
            unique case (code_byte) inside
                CODE_GET:
                begin
                    if (info_len < 32'd4)
                    begin
                        hdr.res.status = ST_GETSHORT;
                    end
                    else
                    begin
                        hdr.res.get_max_len = first_word;
                        info_len = info_len - 32'd4;
                        decl     = (decl < 32'd4) ? 32'd0 : decl - 32'd4;
                        info     = 1'b1;
                    end
                end
                CODE_PUT:
                begin
                    info = 1'b1;
                end
                CODE_SUCCESS:
                begin
                    if (decl != 32'd0)
                    begin
                        info = 1'b1;
                    end
                    else
                    begin
                        hdr.res.status = ST_NODATA;
                    end
                end
                CODE_REJECT_REQ, CODE_REJECT_RSP:
                begin
                    hdr.reject     = 1'b1;
                    hdr.res.status = ST_REJECT;
                end
                CODE_CONT_REQ, CODE_CONT_RSP, CODE_NOT_FOUND, CODE_EXCESS,
                CODE_BAD_REQ, CODE_NOT_IMPL, CODE_UNSUPP:
                begin
                    hdr.res.status = ST_STATUS;
                end
                default:
                begin
                    hdr.res.status = ST_BADCODE;
                end
            endcase
        end

        if (info)
        begin
            if (decl <= info_len)
            begin
                hdr.res.status          = ST_WHOLE;
                hdr.res.fragment_number = 16'd1;
                hdr.res.bytes_received  = info_len;
                hdr.res.bytes_expected  = decl;
            end
            else if (free_avail)
            begin
                hdr.alloc               = 1'b1;
                hdr.res.status          = ST_START;
                hdr.res.fragment_number = 16'd1;
                hdr.res.bytes_received  = info_len;
                hdr.res.bytes_expected  = decl;
            end
            else
            begin
                hdr.res.status = ST_FULL;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/snep_pdu_fragment_tracker_core.sv =====
// ============================================================================
// snep_pdu_fragment_tracker_core
// Tracks fragmented SNEP messages per link key and reports one result per PDU.
// ============================================================================
//
//   channel   handshake             ports
//   -------   -------------------   ---------------------------------------
//   input     start && !busy        adapter .. first_word
//   result    done (one cycle)      status .. bytes_expected
//
// For each item, the accept edge does the key match and issues the table
// memory read, the next cycle modifies and writes back the entry. The
// result word shows with done in the cycle after that, when busy is already
// low, so a new item may be accepted while the result shows. Reset clears the
// valid bits at once; no clearing pass. The receiver cannot stall.
//
`default_nettype none

module snep_pdu_fragment_tracker_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  adapter,
    input  wire logic        dir_tx,
    input  wire logic [5:0]  local_point,
    input  wire logic [5:0]  remote_point,
    input  wire logic [15:0] payload_len,
    input  wire logic [7:0]  version_byte,
    input  wire logic [7:0]  code_byte,
    input  wire logic [31:0] declared_len,
    input  wire logic [31:0] first_word,
    output logic             done,
    output logic [3:0]       status,
    output logic [3:0]       version_major,
    output logic [3:0]       version_minor,
    output logic [31:0]      get_max_len,
    output logic [15:0]      fragment_number,
    output logic [31:0]      bytes_received,
    output logic [31:0]      bytes_expected
);
    import snep_ft_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic        accept;

    key_t        key_in;
    lookup_t     lookup;
    lookup_t     lookup_reg;
    key_t        key_reg;
    logic [15:0] plen_reg;
    logic [7:0]  version_reg;
    logic [7:0]  code_reg;
    logic [31:0] declared_reg;
    logic [31:0] word_reg;

    entry_t      rd_data;
    entry_t      wr_data;
    logic        wr_en;
    idx_t        wr_addr;
    cam_upd_t    upd;
    hdr_t        hdr;

    res_t        res_next;
    res_t        res_reg;

    logic [32:0] sum;
    logic        over;
    logic [15:0] count_inc;

    assign accept = start && !busy_reg;
    assign key_in = {adapter, dir_tx, local_point, remote_point};

    snep_ft_cam u_cam (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_in),
        .upd    (upd),
        .lookup (lookup)
    );

    snep_ft_ram u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (lookup.hit_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    snep_ft_hdr u_hdr (
        .payload_len  (plen_reg),
        .version_byte (version_reg),
        .code_byte    (code_reg),
        .declared_len (declared_reg),
        .first_word   (word_reg),
        .free_avail   (lookup_reg.free_avail),
        .hdr          (hdr)
    );

    // continuation fragment arithmetic
    assign sum       = {1'b0, rd_data.received} + {17'd0, plen_reg};
    assign over      = sum > {1'b0, rd_data.expected};
    assign count_inc = rd_data.count + 16'd1;

    always_comb
    begin
        res_next = hdr.res;
        upd      = '0;
        wr_en    = 1'b0;
        wr_addr  = lookup_reg.free_idx;
        wr_data  = '0;

        if (busy_reg)
        begin
            if (lookup_reg.hit)
            begin
                res_next                = '0;
                res_next.bytes_expected = rd_data.expected;
                wr_addr                 = lookup_reg.hit_idx;
                if (over)
                begin
                    // drop the entry, report counts before this word
                    res_next.status          = ST_OVER;
                    res_next.fragment_number = rd_data.count;
                    res_next.bytes_received  = rd_data.received;
                    upd.clr_en               = 1'b1;
                    upd.clr_idx              = lookup_reg.hit_idx;
                end
                else
                begin
                    res_next.fragment_number = count_inc;
                    res_next.bytes_received  = sum[31:0];
                    wr_en                    = 1'b1;
                    wr_data.count            = count_inc;
                    wr_data.received         = sum[31:0];
                    wr_data.expected         = rd_data.expected;
                    if (sum[31:0] == rd_data.expected)
                    begin
                        res_next.status = ST_DONE;
                        upd.clr_en      = 1'b1;
                        upd.clr_idx     = lookup_reg.hit_idx;
                    end
                    else
                    begin
                        res_next.status = ST_FRAG;
                    end
                end
            end
            else
            begin
                if (hdr.alloc)
                begin
                    upd.set_en       = 1'b1;
                    upd.set_idx      = lookup_reg.free_idx;
                    upd.set_key      = key_reg;
                    wr_en            = 1'b1;
                    wr_data.count    = 16'd1;
                    wr_data.received = hdr.res.bytes_received;
                    wr_data.expected = hdr.res.bytes_expected;
                end
                if (hdr.reject && lookup_reg.rev_hit)
                begin
                    upd.clr_en  = 1'b1;
                    upd.clr_idx = lookup_reg.rev_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
        end
    end

    // capture the input word and its lookup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lookup_reg   <= lookup;
            key_reg      <= key_in;
            plen_reg     <= payload_len;
            version_reg  <= version_byte;
            code_reg     <= code_byte;
            declared_reg <= declared_len;
            word_reg     <= first_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign busy            = busy_reg;
    assign done            = done_reg;
    assign status          = res_reg.status;
    assign version_major   = res_reg.version_major;
    assign version_minor   = res_reg.version_minor;
    assign get_max_len     = res_reg.get_max_len;
    assign fragment_number = res_reg.fragment_number;
    assign bytes_received  = res_reg.bytes_received;
    assign bytes_expected  = res_reg.bytes_expected;

endmodule

`default_nettype wire
